// ----- rtl/core/rlespi_pkg.sv -----
// Shared types and constants for the run-length pixel stream decoder.
package rlespi_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_SLOTS   = 4;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_SEL  = 2'd1,
        KIND_REL  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TRUNC = 2'd1,
        ERR_RUN   = 2'd2
    } t_err;

    localparam logic [8:0] CMD_COL   = 9'h02A;
    localparam logic [8:0] CMD_ROW   = 9'h02B;
    localparam logic [8:0] CMD_WRITE = 9'h02C;
    localparam logic [8:0] DATA_FLAG = 9'h100;
    localparam logic [7:0] ESC_BYTE  = 8'd1;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] display_word;
        logic       last_result;
        logic [1:0] error_code;
        logic       run_pending;
    } t_out;

    typedef struct packed {
        t_kind      kind;
        logic [8:0] word;
    } t_slot;

    // All results caused by one input item.
    typedef struct packed {
        t_slot [MAX_SLOTS-1:0] slot;
        logic [2:0]            cnt;
        t_err                  err;
        logic                  run_pending;
    } t_bundle;

endpackage

// ----- rtl/core/rlespi_front.sv -----
// Front end: parses message bytes and ticks into bundles of result items.
module rlespi_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rlespi_pkg::t_in    i_item,
    input  logic               i_full,
    output logic               o_push,
    output rlespi_pkg::t_bundle o_bundle
);
    import rlespi_pkg::*;

    typedef enum logic [5:0] {
        PH_TYPE    = 6'b000001,
        PH_HEADER  = 6'b000010,
        PH_PAY     = 6'b000100,
        PH_CNT_HI  = 6'b001000,
        PH_CNT_LO  = 6'b010000,
        PH_PATTERN = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_msg, n_msg;
    logic [2:0]  r_hdr, n_hdr;
    logic [1:0]  r_tri, n_tri;
    logic [7:0]  r_cnt_hi, n_cnt_hi;
    logic [15:0] r_repeats, n_repeats;
    logic        r_rel_after, n_rel_after;
    logic [7:0]  r_pat [3];
    logic [7:0]  n_pat [3];

    logic    acc;
    logic    run_act;
    logic    done;
    logic    pat_end;
    t_bundle bnd;

    function automatic t_bundle put(t_bundle b, t_kind k, logic [8:0] w);
        t_bundle r;
        r = b;
        r.slot[b.cnt[1:0]].kind = k;
        r.slot[b.cnt[1:0]].word = w;
        r.cnt = b.cnt + 3'd1;
        return r;
    endfunction

    assign acc     = i_push && !i_full;
    assign run_act = (r_repeats != 16'd0) && (r_phase != PH_PATTERN);

    always_comb begin
        n_phase     = r_phase;
        n_msg       = r_msg;
        n_hdr       = r_hdr;
        n_tri       = r_tri;
        n_cnt_hi    = r_cnt_hi;
        n_repeats   = r_repeats;
        n_rel_after = r_rel_after;
        n_pat       = r_pat;
        done        = 1'b0;
        pat_end     = 1'b0;
        bnd         = '0;
        bnd.err     = ERR_NONE;
        if (acc) begin
            if (run_act) begin
                // send one repetition; a byte that arrives now is dropped
                bnd = put(bnd, KIND_WORD, DATA_FLAG | {1'b0, r_pat[0]});
                bnd = put(bnd, KIND_WORD, DATA_FLAG | {1'b0, r_pat[1]});
                bnd = put(bnd, KIND_WORD, DATA_FLAG | {1'b0, r_pat[2]});
                n_repeats = r_repeats - 16'd1;
                if (n_repeats == 16'd0 && r_rel_after) begin
                    bnd = put(bnd, KIND_REL, 9'd0);
                    n_rel_after = 1'b0;
                end
                if (!i_item.func) begin
                    bnd.err = ERR_RUN;
                end
            end else if (!i_item.func) begin
                unique case (r_phase)
                    PH_HEADER: begin
                        bnd = put(bnd, KIND_WORD, DATA_FLAG | {1'b0, i_item.byte_value});
                        if (r_hdr == 3'd3) begin
                            bnd = put(bnd, KIND_WORD, CMD_ROW);
                        end
                        if (r_hdr == 3'd7) begin
                            bnd     = put(bnd, KIND_WORD, CMD_WRITE);
                            n_hdr   = 3'd0;
                            n_tri   = 2'd0;
                            n_phase = PH_PAY;
                            done    = 1'b1;
                        end else begin
                            n_hdr = r_hdr + 3'd1;
                        end
                    end
                    PH_PAY: begin
                        if (r_tri == 2'd0 && i_item.byte_value == ESC_BYTE) begin
                            n_phase = PH_CNT_HI;
                        end else begin
                            bnd = put(bnd, KIND_WORD, DATA_FLAG | {1'b0, i_item.byte_value});
                            if (r_tri >= 2'd2) begin
                                n_tri = 2'd0;
                                done  = 1'b1;
                            end else begin
                                n_tri = r_tri + 2'd1;
                            end
                        end
                    end
                    PH_CNT_HI: begin
                        n_cnt_hi = i_item.byte_value;
                        n_phase  = PH_CNT_LO;
                    end
                    PH_CNT_LO: begin
                        n_repeats = {r_cnt_hi, i_item.byte_value};
                        if (n_repeats == 16'd0) begin
                            // zero count: escape goes out as a literal pixel byte
                            bnd     = put(bnd, KIND_WORD, DATA_FLAG | {1'b0, ESC_BYTE});
                            n_tri   = 2'd1;
                            n_phase = PH_PAY;
                        end else begin
                            n_tri   = 2'd0;
                            n_phase = PH_PATTERN;
                        end
                    end
                    PH_PATTERN: begin
                        if (r_tri == 2'd0) begin
                            n_pat[0] = i_item.byte_value;
                        end else if (r_tri == 2'd1) begin
                            n_pat[1] = i_item.byte_value;
                        end else begin
                            n_pat[2] = i_item.byte_value;
                        end
                        if (r_tri >= 2'd2) begin
                            n_tri   = 2'd0;
                            n_phase = PH_PAY;
                            done    = 1'b1;
                            pat_end = 1'b1;
                        end else begin
                            n_tri = r_tri + 2'd1;
                        end
                    end
                    PH_TYPE: begin
                        // unknown type codes act as type 2
                        n_msg       = (i_item.byte_value[7:2] == 6'd0) ?
                                      i_item.byte_value[1:0] : 2'd2;
                        n_hdr       = 3'd0;
                        n_tri       = 2'd0;
                        n_rel_after = 1'b0;
                        if (n_msg <= 2'd1) begin
                            bnd     = put(bnd, KIND_SEL, 9'd0);
                            bnd     = put(bnd, KIND_WORD, CMD_COL);
                            n_phase = PH_HEADER;
                        end else begin
                            n_phase = PH_PAY;
                            done    = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_TYPE;
                    end
                endcase
                if (i_item.last_byte) begin
                    if (!done) begin
                        bnd         = put(bnd, KIND_REL, 9'd0);
                        bnd.err     = ERR_TRUNC;
                        n_repeats   = 16'd0;
                        n_rel_after = 1'b0;
                    end else if (pat_end) begin
                        // hold the release until the run finishes
                        n_rel_after = (n_msg == 2'd0 || n_msg == 2'd3);
                    end else if (n_msg == 2'd0 || n_msg == 2'd3) begin
                        bnd = put(bnd, KIND_REL, 9'd0);
                    end
                    n_phase = PH_TYPE;
                    n_hdr   = 3'd0;
                    n_tri   = 2'd0;
                end
            end
        end
        bnd.run_pending = (n_repeats != 16'd0) && (n_phase != PH_PATTERN);
    end

    assign o_push   = acc && (bnd.cnt != 3'd0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_msg       <= 2'd0;
            r_hdr       <= 3'd0;
            r_tri       <= 2'd0;
            r_cnt_hi    <= 8'd0;
            r_repeats   <= 16'd0;
            r_rel_after <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_msg       <= n_msg;
            r_hdr       <= n_hdr;
            r_tri       <= n_tri;
            r_cnt_hi    <= n_cnt_hi;
            r_repeats   <= n_repeats;
            r_rel_after <= n_rel_after;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
    end

    a_tri_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tri != 2'd3)
        else $error("triple position out of range");

    a_release_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel_after |-> r_repeats != 16'd0)
        else $error("deferred release with no run");

endmodule

// ----- rtl/core/rlespi_queue.sv -----
// Short bundle queue between the parser and the result sequencer.
module rlespi_queue #(
    parameter int P_DEPTH = rlespi_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rlespi_pkg::t_bundle i_bundle,
    output logic                o_full,
    input  logic                i_take,
    output logic                o_valid,
    output rlespi_pkg::t_bundle o_bundle
);
    import rlespi_pkg::*;

    localparam int PW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_bundle       r_q [P_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          deq;

    assign o_full   = (r_cnt == CW'(P_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_bundle = r_q[r_rd];
    assign deq      = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(P_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (deq) begin
                r_rd <= (r_rd == PW'(P_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !deq) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && deq) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_bundle;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("bundle written into a full queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(P_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- rtl/core/rlespi_back.sv -----
// Back end: hands out the result items of each bundle one per pop.
module rlespi_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rlespi_pkg::t_bundle i_q_bundle,
    output logic                o_q_take,
    output logic                o_empty,
    input  logic                i_pop,
    output rlespi_pkg::t_out    o_result
);
    import rlespi_pkg::*;

    t_bundle    r_cur;
    logic       r_busy;
    logic [1:0] r_idx;
    logic [2:0] cnt_m1;
    logic       at_last;
    logic       pop_acc;
    t_slot      slot;

    assign cnt_m1   = r_cur.cnt - 3'd1;
    assign at_last  = ({1'b0, r_idx} == cnt_m1);
    assign pop_acc  = i_pop && r_busy;
    // refill when idle, or as the last item of the current bundle leaves
    assign o_q_take = i_q_valid && (!r_busy || (pop_acc && at_last));
    assign o_empty  = !r_busy;
    assign slot     = r_cur.slot[r_idx];

    always_comb begin
        o_result.kind         = slot.kind;
        o_result.display_word = slot.word;
        o_result.last_result  = at_last;
        o_result.error_code   = r_cur.err;
        o_result.run_pending  = r_cur.run_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_q_take) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (pop_acc) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_take) begin
            r_cur <= i_q_bundle;
        end
    end

    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cur.cnt != 3'd0 && r_cur.cnt <= 3'd4))
        else $error("held bundle has no valid item count");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> {1'b0, r_idx} <= cnt_m1)
        else $error("item index past bundle end");

endmodule

// ----- rtl/core/rle_pixel_stream_to_spi_words.sv -----
// An item's first result shows once its bundle is queued, then loaded by the sequencer.
// Throughput: one item per cycle while the queue has room; one result per cycle unless empty.
// An item yields zero to four results; a run repetition yields three or four results.
// The parser, the bundle queue and the result sequencer run decoupled from each other.
// Reset: synchronous, active low; clears parser state, queue and sequencer.
// Pattern byte storage is not reset and is always written before it is read.
module rle_pixel_stream_to_spi_words #(
    parameter int P_QUEUE_DEPTH = rlespi_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  rlespi_pkg::t_in  i_item,
    output logic             empty,
    input  logic             pop,
    output rlespi_pkg::t_out o_result
);
    import rlespi_pkg::*;

    logic    f_push;
    t_bundle f_bundle;
    logic    q_full;
    logic    q_valid;
    logic    q_take;
    t_bundle q_bundle;

    rlespi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_full   (q_full),
        .o_push   (f_push),
        .o_bundle (f_bundle)
    );

    rlespi_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_bundle (f_bundle),
        .o_full   (q_full),
        .i_take   (q_take),
        .o_valid  (q_valid),
        .o_bundle (q_bundle)
    );

    rlespi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_bundle (q_bundle),
        .o_q_take   (q_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

    assign full = q_full;

endmodule
